// ----- rtl/sobel_pkg.sv -----
// ----------------------------------------------------------------------------
// sobel_pkg: shared types, constants and gradient arithmetic
// Sizes of the line buffer and position counters, register indexes and the
// saturating Sobel kernel evaluated on a 3x3 window.
// ----------------------------------------------------------------------------
package sobel_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int WCFG_W = 11;
   localparam int HCFG_W = 13;
   localparam int PIX_W  = 8;

   localparam logic [WCFG_W-1:0] WIDTH_MAX_CFG  = WCFG_W'(MAX_WIDTH);
   localparam logic [HCFG_W-1:0] HEIGHT_MAX_CFG = HCFG_W'(MAX_HEIGHT);

   typedef logic [PIX_W-1:0] pix_type;

   // Window rows 0..2 are top..bottom, columns 0..2 are oldest..newest.
   typedef pix_type [2:0][2:0] win_type;

   typedef enum logic {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      pix_type grad_x;
      pix_type grad_y;
   } grad_type;

   // Border replication: an interior tap uses rows/columns 0,1,2, a tap on
   // the far edge uses 1,2,2.
   function automatic logic [1:0] tap_sel(input logic far_edge, input logic [1:0] pos);
      logic [1:0] sel;
      sel = pos;
      if (far_edge) begin
         sel = (pos == 2'd0) ? 2'd1 : 2'd2;
      end
      return sel;
   endfunction

   function automatic pix_type clamp_diff(input logic [9:0] a, input logic [9:0] b);
      logic [10:0] diff;
      pix_type     res;
      diff = {1'b0, a} - {1'b0, b};
      if (diff[10]) begin
         res = '0;
      end else if (diff[9:8] != 2'b00) begin
         res = '1;
      end else begin
         res = diff[7:0];
      end
      return res;
   endfunction

   function automatic grad_type sobel_grad(input win_type win, input logic row_far,
                                           input logic col_far);
      pix_type    p [3][3];
      logic [9:0] left_sum;
      logic [9:0] right_sum;
      logic [9:0] top_sum;
      logic [9:0] bot_sum;
      grad_type   res;
      for (int a = 0; a < 3; a++) begin
         for (int b = 0; b < 3; b++) begin
            p[a][b] = win[tap_sel(row_far, 2'(a))][tap_sel(col_far, 2'(b))];
         end
      end
      left_sum  = 10'(p[0][0]) + {1'b0, p[1][0], 1'b0} + 10'(p[2][0]);
      right_sum = 10'(p[0][2]) + {1'b0, p[1][2], 1'b0} + 10'(p[2][2]);
      top_sum   = 10'(p[0][0]) + {1'b0, p[0][1], 1'b0} + 10'(p[0][2]);
      bot_sum   = 10'(p[2][0]) + {1'b0, p[2][1], 1'b0} + 10'(p[2][2]);
      res.grad_x = clamp_diff(left_sum, right_sum);
      res.grad_y = clamp_diff(top_sum, bot_sum);
      return res;
   endfunction

endpackage

// ----- rtl/sobel_gradient_3x3.sv -----
// ----------------------------------------------------------------------------
// sobel_gradient_3x3: streaming 3x3 Sobel gradient unit
// Line buffers in one RAM, a 3x3 window and a result sequencer with
// replicated borders.
// ----------------------------------------------------------------------------
// Pixels enter in raster order at up to one per clock. Both line buffers share
// one 1024 x 16 simple dual-port RAM indexed by column: it is read when a pixel
// transfer is accepted and written back (older <= newer, newer <= pixel) when
// that pixel moves on to the result sequencer, with the written word forwarded
// when the next pixel hits the same column (image width of one). Result (r,c)
// leaves when pixel (min(r+1,H-1), min(c+1,W-1)) has been taken; a pixel of the
// first row or the first column yields nothing unless that row or column is
// also the last one, an ordinary pixel yields one result, the last pixel of a
// row or a pixel of the last row yields two, and the last pixel of the frame
// yields four. The result sequencer emits one result per clock while the output
// is not stalled, and the input is held while a pixel's extra results leave.
// A pixel passes the stage 1, stage 2 and output registers before its first
// result. Writing either register restarts the frame at row 0, column 0.
module sobel_gradient_3x3
   import sobel_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] pixel
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [39:0]       rsp_tdata,   // [7:0] grad_x, [15:8] grad_y,
                                          // [27:16] out_row, [37:28] out_col
   output logic              rsp_tlast,   // last result of this pixel
   output logic              rsp_tuser,   // end_of_frame
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [HCFG_W-1:0] csr_wdata
);

   // Configuration (stored as effective, range-limited values).
   logic [WCFG_W-1:0] width_ff;
   logic [HCFG_W-1:0] height_ff;
   logic [COL_W-1:0]  col_ff;
   logic [ROW_W-1:0]  row_ff;

   logic accept;
   logic col_last;
   logic row_last;

   // Line buffer RAM: [15:8] older line, [7:0] newer line.
   logic [2*PIX_W-1:0] lb_mem [MAX_WIDTH];
   logic [2*PIX_W-1:0] lb_rd_ff;
   logic [2*PIX_W-1:0] lb_word;
   logic [2*PIX_W-1:0] lb_wr_data;

   // Stage 1: line buffer data returns, window update and write-back.
   logic               s1_valid_ff;
   pix_type            s1_px_ff;
   logic [COL_W-1:0]   s1_col_ff;
   logic [ROW_W-1:0]   s1_row_ff;
   logic               s1_first_row_ff;
   logic               s1_row_ge2_ff;
   logic               s1_pr_ff, s1_lr_ff, s1_pc_ff, s1_lc_ff;
   logic               s1_fwd_ff;
   logic [2*PIX_W-1:0] s1_fwd_data_ff;
   logic               s1_adv;
   pix_type            col_top, col_mid, col_bot;

   win_type win_ff;
   win_type win_in;

   // Stage 2: result sequencer over the finished window.
   logic             s2_valid_ff;
   logic [COL_W-1:0] s2_col_ff;
   logic [ROW_W-1:0] s2_row_ff;
   logic             s2_pr_ff, s2_lr_ff, s2_pc_ff, s2_lc_ff;
   logic             s2_rsel_ff, s2_csel_ff;
   logic             s2_zero, s2_emit, s2_done, s2_free;
   logic             row_far, col_far, row_is_last, col_is_last, cur_last;
   grad_type         grad;
   logic [ROW_W-1:0] cur_row;
   logic [COL_W-1:0] cur_col;

   logic        rsp_valid_ff;
   logic [39:0] rsp_data_ff;
   logic        rsp_last_ff;
   logic        rsp_eof_ff;
   logic        out_free;

   // ---------------------------------------------------------------- control
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s2_zero    = (!s2_pr_ff && !s2_lr_ff) || (!s2_pc_ff && !s2_lc_ff);
   assign s2_emit    = s2_valid_ff && !s2_zero && out_free;
   assign s2_done    = s2_valid_ff && (s2_zero || (s2_emit && cur_last));
   assign s2_free    = !s2_valid_ff || s2_done;
   assign s1_adv     = s1_valid_ff && s2_free;
   assign req_tready = !s1_valid_ff || s1_adv;
   assign accept     = req_tvalid && req_tready;

   assign col_last = ({1'b0, col_ff} == (width_ff - WCFG_W'(1)));
   assign row_last = ({1'b0, row_ff} == (height_ff - HCFG_W'(1)));

   // ----------------------------------------------------- config / position
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_MAX_CFG;
         height_ff <= HCFG_W'(1024);
         col_ff    <= '0;
         row_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH: begin
               if (csr_wdata[WCFG_W-1:0] == '0) begin
                  width_ff <= WCFG_W'(1);
               end else if (csr_wdata[WCFG_W-1:0] > WIDTH_MAX_CFG) begin
                  width_ff <= WIDTH_MAX_CFG;
               end else begin
                  width_ff <= csr_wdata[WCFG_W-1:0];
               end
            end
            CSR_IMAGE_HEIGHT: begin
               if (csr_wdata == '0) begin
                  height_ff <= HCFG_W'(1);
               end else if (csr_wdata > HEIGHT_MAX_CFG) begin
                  height_ff <= HEIGHT_MAX_CFG;
               end else begin
                  height_ff <= csr_wdata;
               end
            end
            default: begin
            end
         endcase
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         if (col_last) begin
            col_ff <= '0;
            row_ff <= row_last ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_ff <= col_ff + COL_W'(1);
         end
      end
   end

   // ------------------------------------------------------------ line buffer
   assign lb_word    = s1_fwd_ff ? s1_fwd_data_ff : lb_rd_ff;
   assign lb_wr_data = {lb_word[PIX_W-1:0], s1_px_ff};

   always_ff @(posedge clock) begin
      if (accept) begin
         lb_rd_ff <= lb_mem[col_ff];
      end
      if (s1_adv) begin
         lb_mem[s1_col_ff] <= lb_wr_data;
      end
   end

   // ---------------------------------------------------------------- stage 1
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff        <= req_tdata;
         s1_col_ff       <= col_ff;
         s1_row_ff       <= row_ff;
         s1_first_row_ff <= (row_ff == '0);
         s1_row_ge2_ff   <= (row_ff >= ROW_W'(2));
         s1_pr_ff        <= (row_ff != '0);
         s1_lr_ff        <= row_last;
         s1_pc_ff        <= (col_ff != '0);
         s1_lc_ff        <= col_last;
         // The word being written back this same edge is newer than the RAM.
         s1_fwd_ff       <= s1_adv && (s1_col_ff == col_ff);
         s1_fwd_data_ff  <= lb_wr_data;
      end
   end

   always_comb begin
      col_bot = s1_px_ff;
      if (s1_first_row_ff) begin
         col_mid = s1_px_ff;
         col_top = s1_px_ff;
      end else begin
         col_mid = lb_word[PIX_W-1:0];
         col_top = s1_row_ge2_ff ? lb_word[2*PIX_W-1:PIX_W] : lb_word[PIX_W-1:0];
      end
   end

   always_comb begin
      win_in = win_ff;
      for (int k = 0; k < 3; k++) begin
         if (s1_col_ff == '0) begin
            win_in[k][0] = (k == 0) ? col_top : (k == 1) ? col_mid : col_bot;
            win_in[k][1] = win_in[k][0];
         end else begin
            win_in[k][0] = win_ff[k][1];
            win_in[k][1] = win_ff[k][2];
         end
         win_in[k][2] = (k == 0) ? col_top : (k == 1) ? col_mid : col_bot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (s1_adv) begin
         win_ff <= win_in;
      end
   end

   // ---------------------------------------------------------------- stage 2
   assign row_far     = !s2_pr_ff || s2_rsel_ff;
   assign col_far     = !s2_pc_ff || s2_csel_ff;
   assign row_is_last = s2_lr_ff ? row_far : 1'b1;
   assign col_is_last = s2_lc_ff ? col_far : 1'b1;
   assign cur_last    = row_is_last && col_is_last;
   assign cur_row     = row_far ? s2_row_ff : s2_row_ff - ROW_W'(1);
   assign cur_col     = col_far ? s2_col_ff : s2_col_ff - COL_W'(1);
   assign grad        = sobel_grad(win_ff, row_far, col_far);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s2_rsel_ff  <= 1'b0;
         s2_csel_ff  <= 1'b0;
      end else if (s1_adv) begin
         s2_valid_ff <= 1'b1;
         s2_rsel_ff  <= 1'b0;
         s2_csel_ff  <= 1'b0;
      end else if (s2_done) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_emit) begin
         if (col_is_last) begin
            s2_csel_ff <= 1'b0;
            s2_rsel_ff <= 1'b1;
         end else begin
            s2_csel_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_col_ff <= s1_col_ff;
         s2_row_ff <= s1_row_ff;
         s2_pr_ff  <= s1_pr_ff;
         s2_lr_ff  <= s1_lr_ff;
         s2_pc_ff  <= s1_pc_ff;
         s2_lc_ff  <= s1_lc_ff;
      end
   end

   // --------------------------------------------------------- output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_emit) begin
         rsp_data_ff <= {2'b00, cur_col, cur_row, grad.grad_y, grad.grad_x};
         rsp_last_ff <= cur_last;
         // A far-edge row or column tap only exists on the last row or column.
         rsp_eof_ff  <= row_far && col_far;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_eof_ff;

   // ------------------------------------------------------------- assertions
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |-> !req_tready)
      else $error("pixel accepted while stage 1 is held");

   a_eof_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("end of frame result is not the last of its pixel");

   a_s1_reaches_s2: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> s2_valid_ff)
      else $error("stage 1 item lost on its way to the sequencer");

endmodule
